// ----- src/wma_pkg.sv -----
// shared types and constants for the weighted moving average filter
// no dependencies
`timescale 1ns / 1ps

package wma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W = 4;

  localparam logic [CFG_W-1:0] WSIZE_RESET = 4'd12;

  // register index decoded from paddr
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic done;
    logic signed [SAMPLE_W-1:0] quotient;
  } div_result_t;

endpackage

// ----- src/wma_window_mem.sv -----
// sample window memory, one write and one registered read port
// entries read as zero until first written; depends on wma_pkg
`timescale 1ns / 1ps

module wma_window_mem
  import wma_pkg::*;
#(
  parameter int DEPTH = 12,
  parameter int ADDR_W = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  input  logic [ADDR_W-1:0]          raddr,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic signed [SAMPLE_W-1:0] mem_q;
  logic written_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      written_q <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      written_q <= written[raddr];
    end
  end

  assign rdata = written_q ? mem_q : '0;

endmodule

// ----- src/wma_divider.sv -----
// serial restoring divider, one quotient bit per cycle, signed dividend
// truncates toward zero; depends on wma_pkg
`timescale 1ns / 1ps

module wma_divider
  import wma_pkg::*;
#(
  parameter int ACC_W = 23,
  parameter int DEN_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] dividend,
  input  logic [DEN_W-1:0]        divisor,
  output div_result_t             result
);

  localparam int CNT_W = $clog2(SAMPLE_W + 1);

  logic busy;
  logic done;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [SAMPLE_W-1:0] low;
  logic [SAMPLE_W-1:0] quot;
  logic neg;
  logic [ACC_W-1:0] mag;
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic fits;

  always_comb begin
    mag = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
    trial = {rem, low[SAMPLE_W-1]};
    diff = trial - {1'b0, den};
    fits = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(SAMPLE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // quotient magnitude never exceeds 2^15, so the upper dividend bits start below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= mag[ACC_W-1:SAMPLE_W];
      low <= mag[SAMPLE_W-1:0];
      den <= divisor;
      neg <= dividend[ACC_W-1];
      quot <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low <= {low[SAMPLE_W-2:0], 1'b0};
      quot <= {quot[SAMPLE_W-2:0], fits};
    end
  end

  always_comb begin
    result.done = done;
    result.quotient = neg ? $signed(-quot) : $signed(quot);
  end

endmodule

// ----- src/weighted_moving_average_filter.sv -----
// linearly weighted moving average filter, top level
// sequencer, weighted accumulate and config register; uses wma_pkg,
// wma_window_mem and wma_divider
//
// usage:
//   sample_valid/sample_ready carry one signed 16-bit sample per transaction;
//   average_valid/average_ready carry one signed 16-bit average per input.
//   the average covers the window as it stood before the new sample, weights
//   1 (oldest) to N (newest), divided by N(N+1)/2 and truncated toward zero.
//   window_size sits at byte address 0 of the APB port; 0 acts as 1 and
//   values above MAX_TAPS act as MAX_TAPS. write it only while idle.
//   each transaction, from accept to the next accept, makes N reads of
//   the window memory (one port read per cycle, writing each sample but
//   the oldest back one place lower), then runs a serial divide.
//   the average then appears in an output register.
//   a stalled receiver holds the result in that register; the next sample
//   is still taken, and its result waits until the register is freed.
//   reset sets window_size to 12 and makes the whole window read as zero.
`timescale 1ns / 1ps

module weighted_moving_average_filter
  import wma_pkg::*;
#(
  parameter int MAX_TAPS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  output logic signed [SAMPLE_W-1:0] average,
  output logic                       average_valid,
  input  logic                       average_ready
);

  localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_W = $clog2(MAX_TAPS + 1);
  localparam int DEN_MAX = MAX_TAPS * (MAX_TAPS + 1) / 2;
  localparam int DEN_W = $clog2(DEN_MAX + 1);
  localparam int ACC_W = SAMPLE_W + DEN_W;
  localparam int PROD_W = SAMPLE_W + TAP_W + 1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_READ   = 7'b0000010,
    ST_DRAIN  = 7'b0000100,
    ST_FRESH  = 7'b0001000,
    ST_DSTART = 7'b0010000,
    ST_DWAIT  = 7'b0100000,
    ST_HOLD   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0] window_size;
  logic [TAP_W-1:0] taps;
  logic [TAP_W-1:0] taps_next;
  logic signed [SAMPLE_W-1:0] fresh;
  logic [ADDR_W-1:0] rd_idx;
  logic arr_valid;
  logic [ADDR_W-1:0] arr_idx;
  logic prod_valid;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [SAMPLE_W-1:0] quot;

  logic cfg_write;
  logic accept;
  logic last_read;
  logic out_free;
  logic [TAP_W-1:0] weight;
  logic signed [PROD_W-1:0] mult;
  logic [DEN_W:0] den_prod;
  logic [DEN_W-1:0] den;

  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic signed [SAMPLE_W-1:0] mem_rdata;
  div_result_t div_res;

  // config port
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? {{(32 - CFG_W){1'b0}}, window_size} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
    end else if (cfg_write) begin
      window_size <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (window_size == '0) begin
      taps_next = TAP_W'(1);
    end else if (32'(window_size) > MAX_TAPS) begin
      taps_next = TAP_W'(MAX_TAPS);
    end else begin
      taps_next = TAP_W'(window_size);
    end
  end

  assign accept = sample_valid && sample_ready;
  assign sample_ready = (state == ST_IDLE);
  assign last_read = (TAP_W'(rd_idx) == taps - 1'b1);
  assign out_free = !average_valid || average_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_READ;
      ST_READ:   if (last_read) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_FRESH;
      ST_FRESH:  state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT:  if (div_res.done) state_next = ST_HOLD;
      ST_HOLD:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      arr_valid <= 1'b0;
      prod_valid <= 1'b0;
      average_valid <= 1'b0;
    end else begin
      state <= state_next;
      arr_valid <= (state == ST_READ);
      prod_valid <= arr_valid;
      if (state == ST_HOLD && out_free) begin
        average_valid <= 1'b1;
      end else if (average_ready) begin
        average_valid <= 1'b0;
      end
    end
  end

  // read sequencing and weighted accumulate
  assign weight = TAP_W'(arr_idx) + 1'b1;
  assign mult = mem_rdata * $signed({1'b0, weight});

  always_ff @(posedge clk) begin
    if (accept) begin
      taps <= taps_next;
      fresh <= sample;
      rd_idx <= '0;
      acc <= '0;
    end else begin
      if (state == ST_READ && !last_read) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (prod_valid) begin
        acc <= acc + prod;
      end
    end
    arr_idx <= rd_idx;
    prod <= ACC_W'(mult);
    if (state == ST_DWAIT && div_res.done) begin
      quot <= div_res.quotient;
    end
    if (state == ST_HOLD && out_free) begin
      average <= quot;
    end
  end

  // each sample read but the oldest moves down one place; the new sample goes on top
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = arr_idx - 1'b1;
    mem_wdata = mem_rdata;
    if (state == ST_FRESH) begin
      mem_we = 1'b1;
      mem_waddr = ADDR_W'(taps - 1'b1);
      mem_wdata = fresh;
    end else if (arr_valid && arr_idx != '0) begin
      mem_we = 1'b1;
    end
  end

  wma_window_mem #(
    .DEPTH  (MAX_TAPS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx),
    .rdata (mem_rdata)
  );

  assign den_prod = (DEN_W + 1)'(taps) * ((DEN_W + 1)'(taps) + 1'b1);
  assign den = den_prod[DEN_W:1];

  wma_divider #(
    .ACC_W (ACC_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DSTART),
    .dividend (acc),
    .divisor  (den),
    .result   (div_res)
  );

  a_read_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (TAP_W'(rd_idx) < taps))
    else $error("window read beyond active taps");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_READ || state == ST_DRAIN || state == ST_FRESH))
    else $error("window write outside shift phase");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DWAIT))
    else $error("divider finished outside wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_READ && rd_idx == '0))
    else $error("transaction did not start reading");

  a_no_load_over_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && average_valid && !average_ready) |=> (state == ST_HOLD))
    else $error("result left hold while output occupied");

endmodule
